// ----- rtl/hsd_pkg.sv -----
// Shared types and constants for the Huffman stream decoder.
package hsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int PAD_W   = 3;
    localparam int LEN_W   = 13;
    localparam int BIT_W   = 3;
    localparam int CHILD_W = 9;

    // Tree serialisation markers
    localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_ESC  = 8'h5C;

    // Node table entry: a child index of zero means absent
    typedef struct packed {
        logic               leaf;
        logic [BYTE_W-1:0]  sym;
        logic [CHILD_W-1:0] left;
        logic [CHILD_W-1:0] right;
    } t_node;

    typedef enum logic [1:0] {
        ST_SYMBOL   = 2'd0,
        ST_TREE_ERR = 2'd1,
        ST_NO_CHILD = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_TREE,
        PH_DATA
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TREE,
        S_TSTK,
        S_TPAR,
        S_TNEW,
        S_TERR,
        S_TCOUNT,
        S_WALK,
        S_DONE
    } t_state;

    // Result request from sequencer to output stage; close marks end of the byte
    typedef struct packed {
        logic              vld;
        logic              close;
        logic [BYTE_W-1:0] sym;
        t_status           status;
    } t_res_req;

endpackage

// ----- rtl/hsd_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module hsd_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 511
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/hsd_out_reg.sv -----
// Result hold stage and output register; marks the last result of each byte.
module hsd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsd_pkg::t_res_req i_req,
    output logic              o_ok,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [7:0]        o_symbol,
    output logic [1:0]        o_status,
    output logic              o_last_in_run
);
    import hsd_pkg::*;

    logic              r_pend_vld, n_pend_vld;
    logic              r_pend_closed, n_pend_closed;
    logic [BYTE_W-1:0] r_pend_sym;
    t_status           r_pend_status;
    logic              r_out_vld, n_out_vld;
    logic [BYTE_W-1:0] r_out_sym;
    t_status           r_out_status;
    logic              r_out_last;

    logic out_free;
    logic take;
    logic flush;
    logic load;

    // Hold one result until we know whether it closes the byte's run
    always_comb begin
        out_free = !r_out_vld || !i_stall;
        o_ok     = !r_pend_vld || (!r_pend_closed && (out_free || !i_req.vld));
        take     = o_ok && (i_req.vld || i_req.close);
        flush    = r_pend_vld && r_pend_closed && out_free;
        load     = flush || (take && i_req.vld && r_pend_vld);

        n_pend_vld    = r_pend_vld;
        n_pend_closed = r_pend_closed;
        priority if (flush) begin
            n_pend_vld    = 1'b0;
            n_pend_closed = 1'b0;
        end else if (take && i_req.vld) begin
            n_pend_vld    = 1'b1;
            n_pend_closed = i_req.close;
        end else if (take && r_pend_vld) begin
            n_pend_closed = 1'b1;
        end

        n_out_vld = load ? 1'b1 : (r_out_vld && i_stall);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld    <= 1'b0;
            r_pend_closed <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_pend_vld    <= n_pend_vld;
            r_pend_closed <= n_pend_closed;
            r_out_vld     <= n_out_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (take && i_req.vld) begin
            r_pend_sym    <= i_req.sym;
            r_pend_status <= i_req.status;
        end
        if (load) begin
            r_out_sym    <= r_pend_sym;
            r_out_status <= r_pend_status;
            r_out_last   <= flush;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_symbol      = r_out_sym;
    assign o_status      = r_out_status;
    assign o_last_in_run = r_out_last;

endmodule

// ----- rtl/hsd_ctrl.sv -----
// Sequencer: header decode, tree build into node table and stack, bit walk.
module hsd_ctrl #(
    parameter int MAX_NODES   = 511,
    parameter int STACK_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_final_byte,
    output hsd_pkg::t_res_req              o_req,
    input  logic                           i_res_ok,
    output logic                           o_node_we,
    output logic [$clog2(MAX_NODES)-1:0]   o_node_waddr,
    output hsd_pkg::t_node                 o_node_wdata,
    output logic                           o_node_re,
    output logic [$clog2(MAX_NODES)-1:0]   o_node_raddr,
    input  hsd_pkg::t_node                 i_node_rdata,
    output logic                           o_stack_we,
    output logic [$clog2(STACK_DEPTH)-1:0] o_stack_waddr,
    output logic [$clog2(MAX_NODES)-1:0]   o_stack_wdata,
    output logic                           o_stack_re,
    output logic [$clog2(STACK_DEPTH)-1:0] o_stack_raddr,
    input  logic [$clog2(MAX_NODES)-1:0]   i_stack_rdata
);
    import hsd_pkg::*;

    localparam int NADDR_W = $clog2(MAX_NODES);
    localparam int NODE_W  = $clog2(MAX_NODES + 1);
    localparam int SADDR_W = $clog2(STACK_DEPTH);
    localparam int STOP_W  = $clog2(STACK_DEPTH + 1);

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [PAD_W-1:0]   r_pad, n_pad;
    logic [LEN_W-1:0]   r_tree_left, n_tree_left;
    logic               r_esc, n_esc;
    logic               r_tree_bad, n_tree_bad;
    logic               r_at_root, n_at_root;
    logic               r_rd_pend, n_rd_pend;
    logic               r_more, n_more;
    logic [NODE_W-1:0]  r_node_count, n_node_count;
    logic [STOP_W-1:0]  r_stack_top, n_stack_top;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    logic               r_fin, n_fin;
    logic               r_is_int, n_is_int;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [BIT_W-1:0]   r_lo, n_lo;
    t_node              r_cur, n_cur;
    t_node              r_root;
    logic [NADDR_W-1:0] r_par, n_par;

    logic [LEN_W-1:0]   hdr_len;
    logic               tree_esc_byte;
    logic               tree_full_err;
    logic               stk_full;
    logic [STOP_W-1:0]  stk_below;
    logic               tc_last;
    logic               tc_err;
    logic               done_res;
    logic [CHILD_W-1:0] idx_child;
    logic               clear_file;
    t_res_req           req;
    logic               step;

    // Walk datapath
    logic               a_emit;
    logic               a_at_root;
    t_node              a_cur;
    t_node              eff;
    logic [CHILD_W-1:0] child;
    logic               child_bad;
    logic               b_emit;
    logic               b_go;
    logic               w_rd;
    logic               w_more;
    logic               w_done;

    // Decode helpers
    always_comb begin
        hdr_len       = {r_tree_left[LEN_W-1:BYTE_W], i_data_byte};
        tree_esc_byte = !r_esc && (r_byte == CH_ESC);
        tree_full_err = (r_node_count >= NODE_W'(MAX_NODES))
                     || (r_node_count != '0 && r_stack_top == '0);
        stk_full      = (r_stack_top >= STOP_W'(STACK_DEPTH));
        stk_below     = r_stack_top - STOP_W'(1);
        tc_last       = (r_tree_left == LEN_W'(1));
        tc_err        = tc_last && !r_tree_bad
                     && (r_node_count == '0 || r_stack_top != '0 || r_esc);
        done_res      = r_fin && (r_phase != PH_DATA) && !r_tree_bad;
        idx_child     = CHILD_W'(r_node_count);
    end

    // Walk: resolve the previous read (A), then start the next bit (B)
    always_comb begin
        a_emit    = r_rd_pend && i_node_rdata.leaf;
        a_at_root = r_rd_pend ? i_node_rdata.leaf : r_at_root;
        a_cur     = (r_rd_pend && !i_node_rdata.leaf) ? i_node_rdata : r_cur;
        eff       = a_at_root ? r_root : a_cur;
        child     = r_byte[r_bit] ? eff.right : eff.left;
        child_bad = (child == '0) || (child >= idx_child);
        b_emit    = r_root.leaf || child_bad;
        b_go      = r_more && !(a_emit && b_emit);
        w_rd      = b_go && !b_emit;
        w_more    = r_more && !(b_go && (r_bit == r_lo));
        w_done    = !w_rd && !w_more;
    end

    // Result request towards the output stage
    always_comb begin
        req        = '0;
        req.status = ST_SYMBOL;
        unique case (r_state)
            S_TERR: begin
                req.vld    = 1'b1;
                req.status = ST_TREE_ERR;
            end
            S_TCOUNT: begin
                req.vld    = tc_err;
                req.status = ST_TREE_ERR;
            end
            S_WALK: begin
                req.vld   = a_emit || (b_go && b_emit);
                req.close = w_done;
                priority if (a_emit) begin
                    req.sym = i_node_rdata.sym;
                end else if (r_root.leaf) begin
                    req.sym = r_root.sym;
                end else begin
                    req.status = ST_NO_CHILD;
                end
            end
            S_DONE: begin
                req.vld    = done_res;
                req.close  = 1'b1;
                req.status = ST_TREE_ERR;
            end
            default: begin
            end
        endcase
        step = !(req.vld || req.close) || i_res_ok;
    end

    assign o_req   = req;
    assign o_stall = (r_state != S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (r_phase)
                        PH_HDR0: n_state = S_DONE;
                        PH_HDR1: n_state = (hdr_len == '0) ? S_TERR : S_DONE;
                        PH_TREE: n_state = S_TREE;
                        PH_DATA: begin
                            n_state = (r_tree_bad || r_node_count == '0) ? S_DONE : S_WALK;
                        end
                    endcase
                end
            end
            S_TREE: begin
                priority if (r_tree_bad)      n_state = S_TCOUNT;
                else if (tree_esc_byte)       n_state = S_TCOUNT;
                else if (tree_full_err)       n_state = S_TERR;
                else if (r_node_count == '0)  n_state = S_TNEW;
                else                          n_state = S_TSTK;
            end
            S_TSTK: n_state = S_TPAR;
            S_TPAR: n_state = S_TNEW;
            S_TNEW: n_state = (r_is_int && stk_full) ? S_TERR : S_TCOUNT;
            S_TERR: begin
                if (step) begin
                    n_state = (r_phase == PH_DATA) ? S_DONE : S_TCOUNT;
                end
            end
            S_TCOUNT: begin
                if (step) begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                if (step && w_done) begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (step) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_phase      = r_phase;
        n_pad        = r_pad;
        n_tree_left  = r_tree_left;
        n_esc        = r_esc;
        n_tree_bad   = r_tree_bad;
        n_at_root    = r_at_root;
        n_rd_pend    = r_rd_pend;
        n_more       = r_more;
        n_node_count = r_node_count;
        n_stack_top  = r_stack_top;
        n_byte       = r_byte;
        n_fin        = r_fin;
        n_is_int     = r_is_int;
        n_bit        = r_bit;
        n_lo         = r_lo;
        n_cur        = r_cur;
        n_par        = r_par;
        clear_file   = 1'b0;

        o_node_we     = 1'b0;
        o_node_waddr  = r_node_count[NADDR_W-1:0];
        o_node_wdata  = '0;
        o_node_re     = 1'b0;
        o_node_raddr  = i_stack_rdata;
        o_stack_we    = 1'b0;
        o_stack_waddr = r_stack_top[SADDR_W-1:0];
        o_stack_wdata = r_node_count[NADDR_W-1:0];
        o_stack_re    = 1'b0;
        o_stack_raddr = stk_below[SADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_byte = i_data_byte;
                    n_fin  = i_final_byte;
                    unique case (r_phase)
                        PH_HDR0: begin
                            n_pad       = i_data_byte[BYTE_W-1 -: PAD_W];
                            n_tree_left = {i_data_byte[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                            n_phase     = PH_HDR1;
                        end
                        PH_HDR1: begin
                            n_tree_left = hdr_len;
                            n_phase     = (hdr_len == '0) ? PH_DATA : PH_TREE;
                        end
                        PH_TREE: begin
                        end
                        PH_DATA: begin
                            n_bit     = BIT_W'(BYTE_W - 1);
                            n_more    = 1'b1;
                            n_rd_pend = 1'b0;
                            n_lo      = i_final_byte ? r_pad : '0;
                        end
                    endcase
                end
            end
            // Classify the tree byte and fetch the open parent
            S_TREE: begin
                if (!r_tree_bad) begin
                    if (tree_esc_byte) begin
                        n_esc = 1'b1;
                    end else begin
                        n_esc      = 1'b0;
                        n_is_int   = !r_esc && (r_byte == CH_STAR);
                        o_stack_re = !tree_full_err && (r_node_count != '0);
                    end
                end
            end
            S_TSTK: begin
                o_node_re    = 1'b1;
                o_node_raddr = i_stack_rdata;
                n_par        = i_stack_rdata;
            end
            // Attach the new node to its parent; pop once the right child is set
            S_TPAR: begin
                o_node_we    = 1'b1;
                o_node_waddr = r_par;
                o_node_wdata = i_node_rdata;
                if (i_node_rdata.left == '0) begin
                    o_node_wdata.left = idx_child;
                end else begin
                    o_node_wdata.right = idx_child;
                    n_stack_top        = r_stack_top - STOP_W'(1);
                end
            end
            S_TNEW: begin
                if (r_is_int) begin
                    if (!stk_full) begin
                        o_stack_we   = 1'b1;
                        n_stack_top  = r_stack_top + STOP_W'(1);
                        o_node_we    = 1'b1;
                        n_node_count = r_node_count + NODE_W'(1);
                    end
                end else begin
                    o_node_we         = 1'b1;
                    o_node_wdata.leaf = 1'b1;
                    o_node_wdata.sym  = r_byte;
                    n_node_count      = r_node_count + NODE_W'(1);
                end
            end
            S_TERR: begin
                if (step) begin
                    n_tree_bad = 1'b1;
                end
            end
            S_TCOUNT: begin
                if (step) begin
                    n_tree_left = r_tree_left - LEN_W'(1);
                    if (tc_last) begin
                        n_phase = PH_DATA;
                    end
                    if (tc_err) begin
                        n_tree_bad = 1'b1;
                    end
                end
            end
            S_WALK: begin
                if (step) begin
                    n_cur        = a_cur;
                    n_at_root    = (b_go && b_emit) ? 1'b1 : a_at_root;
                    n_rd_pend    = w_rd;
                    n_more       = w_more;
                    o_node_re    = w_rd;
                    o_node_raddr = child[NADDR_W-1:0];
                    if (b_go && r_bit != r_lo) begin
                        n_bit = r_bit - BIT_W'(1);
                    end
                    clear_file = w_done && r_fin;
                end
            end
            S_DONE: begin
                clear_file = step && r_fin;
            end
            default: begin
            end
        endcase

        // End of file: back to the reset state for the next one
        if (clear_file) begin
            n_phase      = PH_HDR0;
            n_pad        = '0;
            n_tree_left  = '0;
            n_esc        = 1'b0;
            n_node_count = '0;
            n_stack_top  = '0;
            n_at_root    = 1'b1;
            n_tree_bad   = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_HDR0;
            r_pad        <= '0;
            r_tree_left  <= '0;
            r_esc        <= 1'b0;
            r_tree_bad   <= 1'b0;
            r_at_root    <= 1'b1;
            r_rd_pend    <= 1'b0;
            r_more       <= 1'b0;
            r_node_count <= '0;
            r_stack_top  <= '0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_pad        <= n_pad;
            r_tree_left  <= n_tree_left;
            r_esc        <= n_esc;
            r_tree_bad   <= n_tree_bad;
            r_at_root    <= n_at_root;
            r_rd_pend    <= n_rd_pend;
            r_more       <= n_more;
            r_node_count <= n_node_count;
            r_stack_top  <= n_stack_top;
        end
    end

    // Payload, plus a copy of the root entry mirrored from node-table writes
    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_fin    <= n_fin;
        r_is_int <= n_is_int;
        r_bit    <= n_bit;
        r_lo     <= n_lo;
        r_cur    <= n_cur;
        r_par    <= n_par;
        if (o_node_we && o_node_waddr == '0) begin
            r_root <= o_node_wdata;
        end
    end

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_node_we && o_node_re))
        else $error("node table read and written in the same cycle");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stack_top <= STOP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_count <= NODE_W'(MAX_NODES))
        else $error("node count beyond table size");

    a_rd_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == S_WALK))
        else $error("walk read outstanding outside the walk");

    a_walk_read_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && o_node_re) |=> r_rd_pend)
        else $error("walk read issued but not tracked");
`endif

endmodule

// ----- rtl/huffman_stream_decoder_unit.sv -----
// Huffman stream decoder top level: one compressed byte per input transaction, one at a time.
// Header bytes are decoded directly; a tree byte goes through stack read, parent read-modify-write,
// node write and error report as needed; coded bytes are walked bit by bit from the MSB down,
// skipping the pad bits of the final byte, and are passed over once the tree has failed. A result
// waits for the next one or its byte's end before it reaches o_valid. Reset: synchronous, active low.
module huffman_stream_decoder_unit #(
    parameter int MAX_NODES   = 511,
    parameter int STACK_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_symbol,
    output logic [1:0] o_status,
    output logic       o_last_in_run
);
    import hsd_pkg::*;

    localparam int NADDR_W = $clog2(MAX_NODES);
    localparam int SADDR_W = $clog2(STACK_DEPTH);

    t_res_req           req;
    logic               res_ok;
    logic               node_we;
    logic [NADDR_W-1:0] node_waddr;
    t_node              node_wdata;
    logic               node_re;
    logic [NADDR_W-1:0] node_raddr;
    t_node              node_rdata;
    logic               stack_we;
    logic [SADDR_W-1:0] stack_waddr;
    logic [NADDR_W-1:0] stack_wdata;
    logic               stack_re;
    logic [SADDR_W-1:0] stack_raddr;
    logic [NADDR_W-1:0] stack_rdata;

    // Sequencer
    hsd_ctrl #(
        .MAX_NODES   (MAX_NODES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .o_req         (req),
        .i_res_ok      (res_ok),
        .o_node_we     (node_we),
        .o_node_waddr  (node_waddr),
        .o_node_wdata  (node_wdata),
        .o_node_re     (node_re),
        .o_node_raddr  (node_raddr),
        .i_node_rdata  (node_rdata),
        .o_stack_we    (stack_we),
        .o_stack_waddr (stack_waddr),
        .o_stack_wdata (stack_wdata),
        .o_stack_re    (stack_re),
        .o_stack_raddr (stack_raddr),
        .i_stack_rdata (stack_rdata)
    );

    // Node table
    hsd_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // Stack of internal nodes still missing a right child
    hsd_ram #(
        .WIDTH (NADDR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_re    (stack_re),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    // Output hold stage and register
    hsd_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .o_ok          (res_ok),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_symbol      (o_symbol),
        .o_status      (o_status),
        .o_last_in_run (o_last_in_run)
    );

endmodule
